// File: hdl/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg: shared types and constants of the order book level tracker
// Holds the transaction formats, the level table sizes and the control
// structures passed between the top level, the side tables and the cells.
// ----------------------------------------------------------------------------
package obl_pkg;

    localparam int LEVELS     = 256;
    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 32;
    localparam int MID_BITS   = PRICE_BITS + 1;
    localparam int CNT_W      = $clog2(LEVELS + 1);

    // The hit flags of a side are reduced through one registered level of groups.
    localparam int GROUP_SIZE = 16;
    localparam int GROUPS     = (LEVELS + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef struct packed {
        logic                  side;
        logic [PRICE_BITS-1:0] level_price;
        logic [QTY_BITS-1:0]   level_quantity;
        logic                  end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] best_bid;
        logic [PRICE_BITS-1:0] best_ask;
        logic [MID_BITS-1:0]   mid_price_halfticks;
        logic                  one_sided;
        logic                  levels_dropped;
    } out_item_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } level_entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_UPDATE,
        OP_REMOVE,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic                  ask;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } cell_cmd_t;

    typedef struct packed {
        logic                  ask;
        logic                  find;
        logic                  apply;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } side_ctrl_t;

    typedef struct packed {
        logic                  nonempty;
        logic                  drop;
        logic [PRICE_BITS-1:0] best_price;
    } side_stat_t;

endpackage

// File: hdl/obl_cell.sv
// ----------------------------------------------------------------------------
// obl_cell: one price level slot of a sorted side table
// Compares its level against the broadcast price and takes its own, its
// left or right neighbour's, or the new level according to the command.
// ----------------------------------------------------------------------------
module obl_cell (
    input  logic                 aclk,
    input  obl_pkg::cell_cmd_t   cmd,
    input  logic                 occupied,
    input  logic                 left_ahead,
    input  obl_pkg::level_entry_t left_entry,
    input  obl_pkg::level_entry_t right_entry,
    output obl_pkg::level_entry_t entry,
    output logic                 ahead,
    output logic                 hit
);
    import obl_pkg::*;

    level_entry_t entry_reg;
    level_entry_t entry_next;
    level_entry_t new_entry;

    // Bids rank higher prices first, asks lower prices first.
    always_comb begin
        if (cmd.ask) begin
            ahead = occupied && (entry_reg.price < cmd.price);
        end else begin
            ahead = occupied && (entry_reg.price > cmd.price);
        end
        hit = occupied && (entry_reg.price == cmd.price);
    end

    always_comb begin
        new_entry.price = cmd.price;
        new_entry.qty   = cmd.qty;
        entry_next      = entry_reg;
        unique case (cmd.op)
            OP_HOLD: begin
                entry_next = entry_reg;
            end
            OP_UPDATE: begin
                if (hit) begin
                    entry_next.qty = cmd.qty;
                end
            end
            OP_REMOVE: begin
                if (!ahead) begin
                    entry_next = right_entry;
                end
            end
            OP_INSERT: begin
                if (!ahead) begin
                    entry_next = left_ahead ? new_entry : left_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: hdl/obl_side.sv
// ----------------------------------------------------------------------------
// obl_side: sorted price level table for one side of the book
// A row of cells kept best first, with the level count, a registered
// reduction of the price hit flags and the choice of table operation.
// ----------------------------------------------------------------------------
module obl_side (
    input  logic                aclk,
    input  logic                aresetn,
    input  obl_pkg::side_ctrl_t ctrl,
    output obl_pkg::side_stat_t stat
);
    import obl_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [GROUPS-1:0] group_hit_reg;
    logic [GROUPS-1:0] group_hit_next;

    level_entry_t                    entries [LEVELS];
    logic [LEVELS-1:0]               aheads;
    logic [LEVELS-1:0]               hits;
    logic [GROUPS*GROUP_SIZE-1:0]    hits_pad;
    cell_cmd_t                       cmd;
    logic                            found;
    logic                            full;

    assign found = |group_hit_reg;
    assign full  = (count_reg == CNT_W'(LEVELS));

    always_comb begin
        cmd.ask   = ctrl.ask;
        cmd.price = ctrl.price;
        cmd.qty   = ctrl.qty;
        cmd.op    = OP_HOLD;
        if (ctrl.apply) begin
            if (found) begin
                cmd.op = (ctrl.qty == '0) ? OP_REMOVE : OP_UPDATE;
            end else if (ctrl.qty != '0) begin
                cmd.op = OP_INSERT;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.op == OP_REMOVE) begin
            count_next = count_reg - CNT_W'(1);
        end else if ((cmd.op == OP_INSERT) && !full) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign hits_pad = (GROUPS*GROUP_SIZE)'(hits);

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            group_hit_next[g] = |hits_pad[g*GROUP_SIZE +: GROUP_SIZE];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            group_hit_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (ctrl.find) begin
                group_hit_reg <= group_hit_next;
            end
        end
    end

    for (genvar i = 0; i < LEVELS; i++) begin : g_cell
        logic         occupied;
        logic         left_ahead;
        level_entry_t left_entry;
        level_entry_t right_entry;

        assign occupied = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_ahead = 1'b1;
            assign left_entry = '0;
        end else begin : g_body
            assign left_ahead = aheads[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == LEVELS - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end

        obl_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occupied    (occupied),
            .left_ahead  (left_ahead),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .ahead       (aheads[i]),
            .hit         (hits[i])
        );
    end

    assign stat.nonempty   = (count_reg != '0);
    assign stat.drop       = (cmd.op == OP_INSERT) && full;
    assign stat.best_price = entries[0].price;

endmodule

// File: hdl/order_book_level_tracker.sv
// ----------------------------------------------------------------------------
// order_book_level_tracker: bid and ask price level tables with mid report
// A new transaction is taken only once the last is through: it passes the price
// search, the registered hit reduction and the table update, and an end-of-message
// transaction passes the report step as well.
// Reset (aresetn low, synchronous) empties both tables and clears all flags.
// ----------------------------------------------------------------------------
//
// Each side of the book is a row of level cells held best first: bids by
// descending price, asks by ascending price. A transaction goes through
// three steps. In the first it is captured. In the second every cell of the
// addressed side compares its price with the update and the hit flags are
// reduced in groups into registers. In the third the side decides whether
// the price is present, and every cell moves at once: an update rewrites the
// matching quantity, a removal pulls the levels behind it one place forward,
// and an insertion pushes them one place back, the last cell falling off
// when the side is full. A full side taking a new price sets a sticky drop
// flag, which is reported and cleared with the next report.
//
// On the last transaction of a message a fourth step loads the output
// register with the best bid, the best ask and their sum. An empty side
// reads as zero, and the mid price reads as zero and one_sided is raised
// whenever either side is empty. The output register frees the input side:
// a new transaction is accepted while an earlier report waits to be taken.
// ----------------------------------------------------------------------------
module order_book_level_tracker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  obl_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output obl_pkg::out_item_t m_data
);
    import obl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_APPLY,
        ST_REPORT
    } state_t;

    state_t     state_reg;
    in_item_t   item_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic       drop_seen_reg;

    side_ctrl_t bid_ctrl;
    side_ctrl_t ask_ctrl;
    side_stat_t bid_stat;
    side_stat_t ask_stat;
    out_item_t  report;

    // Only the side named by the held transaction searches and updates.
    always_comb begin
        bid_ctrl.ask   = 1'b0;
        bid_ctrl.price = item_reg.level_price;
        bid_ctrl.qty   = item_reg.level_quantity;
        bid_ctrl.find  = (state_reg == ST_FIND) && !item_reg.side;
        bid_ctrl.apply = (state_reg == ST_APPLY) && !item_reg.side;

        ask_ctrl.ask   = 1'b1;
        ask_ctrl.price = item_reg.level_price;
        ask_ctrl.qty   = item_reg.level_quantity;
        ask_ctrl.find  = (state_reg == ST_FIND) && item_reg.side;
        ask_ctrl.apply = (state_reg == ST_APPLY) && item_reg.side;
    end

    obl_side u_bid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bid_ctrl),
        .stat    (bid_stat)
    );

    obl_side u_ask (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ask_ctrl),
        .stat    (ask_stat)
    );

    // The report is formed from the table heads after the update has landed.
    always_comb begin
        report.best_bid            = bid_stat.nonempty ? bid_stat.best_price : '0;
        report.best_ask            = ask_stat.nonempty ? ask_stat.best_price : '0;
        report.one_sided           = !bid_stat.nonempty || !ask_stat.nonempty;
        report.mid_price_halfticks = '0;
        if (!report.one_sided) begin
            report.mid_price_halfticks = MID_BITS'(report.best_bid)
                                       + MID_BITS'(report.best_ask);
        end
        report.levels_dropped      = drop_seen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            drop_seen_reg <= 1'b0;
        end else begin
            // In the report step the output register is reloaded there instead.
            if (m_valid_reg && m_ready && (state_reg != ST_REPORT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (bid_stat.drop || ask_stat.drop) begin
                        drop_seen_reg <= 1'b1;
                    end
                    state_reg <= item_reg.end_of_message ? ST_REPORT : ST_IDLE;
                end
                ST_REPORT: begin
                    // Wait here only while an earlier report is still held.
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg    <= report;
                        m_valid_reg   <= 1'b1;
                        drop_seen_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: tb/obl_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_tb_pkg: level book predictor and report scoreboard
// Keeps its own bid and ask books, works out the report due on each
// end-of-message transaction and compares the reports of the block with it.
// ----------------------------------------------------------------------------
package obl_tb_pkg;

    import obl_pkg::*;

    localparam bit SIDE_BID = 1'b0;
    localparam bit SIDE_ASK = 1'b1;

    class order_book_scoreboard;

        level_entry_t bid_levels[$];
        level_entry_t ask_levels[$];
        bit           drop_in_message;
        out_item_t    expected_reports[$];
        int unsigned  mismatches;
        int unsigned  reports_checked;

        function new();
            drop_in_message = 1'b0;
            mismatches      = 0;
            reports_checked = 0;
        endfunction

        function bit ranks_ahead(bit ask, logic [PRICE_BITS-1:0] a, logic [PRICE_BITS-1:0] b);
            return ask ? (a < b) : (a > b);
        endfunction

        // Insert, overwrite or remove one level, keeping the side best first.
        function void apply_level(bit ask, logic [PRICE_BITS-1:0] price,
                                  logic [QTY_BITS-1:0] qty);
            level_entry_t book[$];
            level_entry_t fresh;
            int           pos;
            if (ask) begin
                book = ask_levels;
            end else begin
                book = bid_levels;
            end
            fresh.price = price;
            fresh.qty   = qty;
            pos = 0;
            while (pos < book.size() && ranks_ahead(ask, book[pos].price, price)) begin
                pos++;
            end
            if (pos < book.size() && book[pos].price == price) begin
                if (qty == '0) begin
                    book.delete(pos);
                end else begin
                    book[pos].qty = qty;
                end
            end else if (qty != '0) begin
                if (book.size() == LEVELS) begin
                    // A full side loses its worst level, which may be the new one.
                    drop_in_message = 1'b1;
                    if (pos < LEVELS) begin
                        void'(book.pop_back());
                        book.insert(pos, fresh);
                    end
                end else begin
                    book.insert(pos, fresh);
                end
            end
            if (ask) begin
                ask_levels = book;
            end else begin
                bid_levels = book;
            end
        endfunction

        function void note_level_update(in_item_t item);
            out_item_t report;
            apply_level(item.side, item.level_price, item.level_quantity);
            if (item.end_of_message) begin
                report.best_bid  = (bid_levels.size() > 0) ? bid_levels[0].price : '0;
                report.best_ask  = (ask_levels.size() > 0) ? ask_levels[0].price : '0;
                report.one_sided = (bid_levels.size() == 0) || (ask_levels.size() == 0);
                report.mid_price_halfticks = report.one_sided ? '0 :
                    {1'b0, report.best_bid} + {1'b0, report.best_ask};
                report.levels_dropped = drop_in_message;
                drop_in_message = 1'b0;
                expected_reports.push_back(report);
            end
        endfunction

        function int unsigned reports_outstanding();
            return expected_reports.size();
        endfunction

        // Draws a price currently resting on the given side, if there is one.
        function bit pick_held_price(bit ask, output logic [PRICE_BITS-1:0] price);
            price = '0;
            if (ask) begin
                if (ask_levels.size() == 0) return 1'b0;
                price = ask_levels[$urandom_range(0, ask_levels.size() - 1)].price;
            end else begin
                if (bid_levels.size() == 0) return 1'b0;
                price = bid_levels[$urandom_range(0, bid_levels.size() - 1)].price;
            end
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_field(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("report %0d %s got %0h expected %0h",
                                          reports_checked, field, got, want));
            end
        endtask

        task check_report(out_item_t got);
            out_item_t want;
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("report %0d arrived with none due", reports_checked));
                reports_checked++;
                return;
            end
            want = expected_reports.pop_front();
            check_field("best_bid", 64'(got.best_bid), 64'(want.best_bid));
            check_field("best_ask", 64'(got.best_ask), 64'(want.best_ask));
            check_field("mid_price_halfticks", 64'(got.mid_price_halfticks),
                        64'(want.mid_price_halfticks));
            check_field("one_sided", 64'(got.one_sided), 64'(want.one_sided));
            check_field("levels_dropped", 64'(got.levels_dropped), 64'(want.levels_dropped));
            reports_checked++;
        endtask

    endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the order book level tracker
// Drives level updates into the block with random gaps, takes its mid price
// reports with random stalls and one long hold-off, and checks every report
// against a predictor that keeps its own copy of both sides of the book.
// ----------------------------------------------------------------------------
module tb_top;

    import obl_pkg::*;
    import obl_tb_pkg::*;

    // The limit lies far above the length of a correct run.
    localparam int unsigned CYCLE_LIMIT        = 200000;
    // The receiver holds off once, after this many reports, for this many cycles.
    localparam int unsigned HOLD_AFTER_REPORTS = 100;
    localparam int unsigned HOLD_CYCLES        = 300;
    // Margin after the last due report, in which a stray report would still be caught.
    localparam int unsigned DRAIN_CYCLES       = 20;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    order_book_scoreboard book_scoreboard;
    // While set, neither side idles, so that transactions run back to back.
    bit          burst_mode;
    int unsigned cycle_count;

    order_book_level_tracker DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The run is cut short if the block stops making progress.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL order_book_level_tracker");
            $finish;
        end
    end

    // Both channels are observed at the rising edge. The report is checked
    // before the input is noted, although a report can never belong to a
    // transaction accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_valid && m_ready) begin
                book_scoreboard.check_report(m_data);
            end
            if (s_valid && s_ready) begin
                book_scoreboard.note_level_update(s_data);
            end
        end
    end

    // Offers one transaction after a random gap and returns once it has been
    // accepted, at the following falling edge. Valid stays high between
    // transactions when no gap is drawn.
    task automatic drive_level(bit ask, logic [PRICE_BITS-1:0] price,
                               logic [QTY_BITS-1:0] qty, bit eom);
        in_item_t    item;
        int unsigned gap;
        item.side           = ask;
        item.level_price    = price;
        item.level_quantity = qty;
        item.end_of_message = eom;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Busy trading around a narrow, partly crossed range: plenty of updates
    // and removals of prices that are held, and some of prices that are not.
    task automatic run_churn(int unsigned count);
        bit                    ask;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        for (int unsigned i = 0; i < count; i++) begin
            burst_mode = (i < 120);
            ask   = $urandom_range(0, 1);
            price = ask ? $urandom_range(1030, 1070) : $urandom_range(1000, 1040);
            qty   = ($urandom_range(0, 9) < 3) ? '0 : $urandom;
            drive_level(ask, price, qty, $urandom_range(0, 3) == 0);
        end
        burst_mode = 1'b0;
    endtask

    // Mostly new prices on one side, so that it fills up and starts to drop
    // levels. Bid prices stay low; ask prices span the whole field.
    task automatic run_fill(bit ask, int unsigned count);
        bit                    sd;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        for (int unsigned i = 0; i < count; i++) begin
            sd = ask;
            if ($urandom_range(0, 19) == 0) begin
                sd = !ask;
            end
            if (sd != ask) begin
                price = (sd == SIDE_ASK) ? $urandom_range(1030, 1070) :
                                           $urandom_range(1000, 1040);
            end else if (ask == SIDE_ASK) begin
                price = $urandom;
            end else begin
                price = $urandom_range(0, 200000);
            end
            qty = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
            drive_level(sd, price, qty, $urandom_range(0, 3) == 0);
        end
    endtask

    // Mostly removals of resting levels, some overwrites, a little noise.
    task automatic run_drain(int unsigned count);
        bit                    ask;
        bit                    found;
        int unsigned           pick;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        for (int unsigned i = 0; i < count; i++) begin
            burst_mode = (i < 100);
            ask   = $urandom_range(0, 1);
            pick  = $urandom_range(0, 19);
            found = book_scoreboard.pick_held_price(ask, price);
            if (found && pick < 15) begin
                qty = '0;
            end else if (found && pick < 18) begin
                qty = $urandom;
            end else begin
                price = ask ? $urandom_range(1030, 1070) : $urandom_range(1000, 1040);
                qty   = $urandom;
            end
            drive_level(ask, price, qty, $urandom_range(0, 2) == 0);
        end
        burst_mode = 1'b0;
    endtask

    // Receiver: a random stall before each report, and one long hold-off
    // during which the sender keeps offering, so that the block backs up.
    initial begin : report_sink
        int unsigned gap;
        int unsigned reports_taken;
        m_ready = 1'b0;
        reports_taken = 0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        @(negedge aclk);
        forever begin
            if (reports_taken == HOLD_AFTER_REPORTS) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = burst_mode ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            reports_taken++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        book_scoreboard = new();
        burst_mode = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Removing an absent price from an empty book: both sides read zero.
        drive_level(SIDE_ASK, 32'd500, '0, 1'b1);
        // Bids only, so the book is one-sided.
        drive_level(SIDE_BID, 32'd100, 32'd5, 1'b1);
        drive_level(SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Highest bid and highest ask give the largest mid price.
        drive_level(SIDE_BID, 32'hFFFF_FFFF, 32'd1, 1'b1);
        // A two-item message: removal of the best bid and an overwrite.
        drive_level(SIDE_BID, 32'hFFFF_FFFF, '0, 1'b0);
        drive_level(SIDE_BID, 32'd100, 32'd9, 1'b1);
        // A resting ask at price zero still counts as a two-sided book.
        drive_level(SIDE_ASK, '0, 32'd3, 1'b1);
        drive_level(SIDE_BID, '0, 32'hFFFF_FFFF, 1'b0);
        drive_level(SIDE_BID, 32'd12345, '0, 1'b1);
        drive_level(SIDE_ASK, 32'd200, 32'd4, 1'b0);
        drive_level(SIDE_ASK, 32'd200, 32'd8, 1'b0);
        drive_level(SIDE_ASK, '0, '0, 1'b1);
        // Emptying the ask side with bids still resting.
        drive_level(SIDE_ASK, 32'hFFFF_FFFF, '0, 1'b0);
        drive_level(SIDE_ASK, 32'd200, '0, 1'b1);
        // Emptying the bid side as well.
        drive_level(SIDE_BID, 32'd100, '0, 1'b0);
        drive_level(SIDE_BID, '0, '0, 1'b1);
        drive_level(SIDE_BID, 32'h8000_0000, 32'h8000_0000, 1'b0);
        drive_level(SIDE_ASK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);

        run_churn(350);
        run_fill(SIDE_BID, 340);
        run_fill(SIDE_ASK, 340);
        run_drain(420);
        s_valid <= 1'b0;

        while (book_scoreboard.reports_outstanding() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book_scoreboard.mismatches == 0) begin
            $display("PASS order_book_level_tracker");
        end else begin
            $display("FAIL order_book_level_tracker");
        end
        $finish;
    end

endmodule
